>>> sv/gdt_pkg.sv
// Shared types and constants for the domino tiling check block.
// Depends on nothing; every other file imports it.
package gdt_pkg;

    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 32;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CELL_W   = ROW_W + COL_W;
    localparam int CELLS    = 1 << CELL_W;
    localparam int SP_W     = CELL_W + 1;
    localparam int SZ_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    typedef struct packed {
        logic       func;
        logic [4:0] hole_row;
        logic [4:0] hole_col;
    } in_t;

    typedef struct packed {
        logic        tileable;
        logic [9:0]  matched_pairs;
        logic [10:0] free_cells;
    } out_t;

    typedef struct packed {
        logic [SZ_W-1:0] rows;
        logic [SZ_W-1:0] cols;
    } size_t;

    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } mark_t;

    typedef struct packed {
        logic             clr;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } query_t;

    typedef struct packed {
        logic [CELL_W-1:0] node;
        logic [2:0]        dir;
        logic [CELL_W-1:0] via;
    } frame_t;

    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] node;
    } partner_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_STEP,
        S_POP,
        S_NREAD,
        S_WREAD,
        S_BT_A,
        S_BT_B,
        S_BT_LD,
        S_DONE
    } state_t;

endpackage

>>> sv/gdt_map.sv
// Blocked-cell map: one flop per cell, single lookup port, whole-map clear on query.clr.
// Depends on gdt_pkg.
module gdt_map (
    input  logic           clk,
    input  logic           rst_n,
    input  gdt_pkg::mark_t  mark,
    input  gdt_pkg::query_t query,
    output logic           blocked
);
    import gdt_pkg::*;

    logic [MAX_COLS-1:0] blk_reg [MAX_ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                blk_reg[i] <= '0;
            end
        end
        else if (query.clr)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                blk_reg[i] <= '0;
            end
        end
        else if (mark.we)
        begin
            blk_reg[mark.row][mark.col] <= 1'b1;
        end
    end

    // non power-of-two sizes leave unused codes; they read as free
    always_comb
    begin
        if ((32'(query.row) < MAX_ROWS) && (32'(query.col) < MAX_COLS))
            blocked = blk_reg[query.row][query.col];
        else
            blocked = 1'b0;
    end

endmodule

>>> sv/gdt_search.sv
// Matching sequencer: clear sweep, free count, augmenting-path DFS per free even-parity cell.
// Partner, visit stamp and DFS stack live in memories with registered reads. Uses gdt_pkg.
module gdt_search (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  gdt_pkg::size_t  size,
    input  logic            blocked,
    input  logic            take,
    output gdt_pkg::query_t query,
    output logic            idle,
    output logic            res_valid,
    output gdt_pkg::out_t   res
);
    import gdt_pkg::*;

    partner_t            partner_mem [CELLS];
    logic [CELL_W:0]     stamp_mem   [CELLS];
    frame_t              stack_mem   [CELLS];

    state_t              state_reg, state_next;
    logic [CELL_W:0]     cnt_reg, cnt_next;
    logic [CELL_W:0]     free_reg, free_next;
    logic [CELL_W:0]     pairs_reg, pairs_next;
    logic [CELL_W:0]     id_reg, id_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    frame_t              top_reg, top_next;
    logic [CELL_W-1:0]   v_reg, v_next;
    logic [CELL_W-1:0]   w_reg, w_next;

    logic                p_we, s_we, k_we;
    logic [CELL_W-1:0]   p_waddr, p_raddr, s_waddr, s_raddr, k_waddr, k_raddr;
    partner_t            p_wdata, p_rdata;
    logic [CELL_W:0]     s_wdata, s_rdata;
    frame_t              k_wdata, k_rdata;

    logic [ROW_W-1:0]    cr, tr;
    logic [COL_W-1:0]    cc, tc;
    logic                cell_act;
    logic [ROW_W:0]      r_inc;
    logic [COL_W:0]      c_inc;
    logic                nbr_in;
    logic [CELL_W-1:0]   nbr;

    assign cr = cnt_reg[CELL_W-1:COL_W];
    assign cc = cnt_reg[COL_W-1:0];
    assign tr = top_reg.node[CELL_W-1:COL_W];
    assign tc = top_reg.node[COL_W-1:0];
    assign cell_act = (SZ_W'(cr) < size.rows) && (SZ_W'(cc) < size.cols);
    assign r_inc = {1'b0, tr} + 1'b1;
    assign c_inc = {1'b0, tc} + 1'b1;

    // neighbor order: down, right, left, up
    always_comb
    begin
        case (top_reg.dir[1:0])
            2'd0:
            begin
                nbr_in = SZ_W'(r_inc) < size.rows;
                nbr    = {r_inc[ROW_W-1:0], tc};
            end
            2'd1:
            begin
                nbr_in = SZ_W'(c_inc) < size.cols;
                nbr    = {tr, c_inc[COL_W-1:0]};
            end
            2'd2:
            begin
                nbr_in = (tc != '0);
                nbr    = {tr, tc - 1'b1};
            end
            default:
            begin
                nbr_in = (tr != '0);
                nbr    = {tr - 1'b1, tc};
            end
        endcase
    end

    always_comb
    begin
        query.clr = (state_reg == S_DONE) && take;
        if (state_reg == S_STEP)
        begin
            query.row = nbr[CELL_W-1:COL_W];
            query.col = nbr[COL_W-1:0];
        end
        else
        begin
            query.row = cr;
            query.col = cc;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start) state_next = S_CLEAR;
            S_CLEAR:
                if (cnt_reg[CELL_W-1:0] == '1) state_next = S_SCAN;
            S_SCAN:
                if (cnt_reg[CELL_W])
                    state_next = S_DONE;
                else if (cell_act && !blocked && !(cr[0] ^ cc[0]))
                    state_next = S_STEP;
            S_STEP:
                if (sp_reg == '0)
                    state_next = S_SCAN;
                else if (top_reg.dir[2])
                begin
                    if (sp_reg > SP_W'(1)) state_next = S_POP;
                end
                else if (nbr_in && !blocked)
                    state_next = S_NREAD;
            S_POP:
                state_next = S_STEP;
            S_NREAD:
                state_next = p_rdata.valid ? S_WREAD : S_BT_A;
            S_WREAD:
                state_next = S_STEP;
            S_BT_A:
                state_next = S_BT_B;
            S_BT_B:
                state_next = (sp_reg == SP_W'(1)) ? S_SCAN : S_BT_LD;
            S_BT_LD:
                state_next = S_BT_A;
            S_DONE:
                if (take) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cnt_next   = cnt_reg;
        free_next  = free_reg;
        pairs_next = pairs_reg;
        id_next    = id_reg;
        sp_next    = sp_reg;
        top_next   = top_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        p_we = 1'b0; p_waddr = cnt_reg[CELL_W-1:0]; p_wdata = '0;
        p_raddr = nbr;
        s_we = 1'b0; s_waddr = cnt_reg[CELL_W-1:0]; s_wdata = '0;
        s_raddr = p_rdata.node;
        k_we = 1'b0; k_waddr = CELL_W'(sp_reg - 1'b1); k_wdata = top_reg;
        k_raddr = CELL_W'(sp_reg - SP_W'(2));
        case (state_reg)
            S_IDLE:
            begin
                cnt_next  = '0;
                free_next = '0;
            end
            S_CLEAR:
            begin
                p_we = 1'b1;
                s_we = 1'b1;
                if (cell_act && !blocked) free_next = free_reg + 1'b1;
                if (cnt_reg[CELL_W-1:0] == '1)
                begin
                    cnt_next   = '0;
                    pairs_next = '0;
                    id_next    = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SCAN:
            begin
                if (!cnt_reg[CELL_W])
                begin
                    if (cell_act && !blocked && !(cr[0] ^ cc[0]))
                    begin
                        id_next  = id_reg + 1'b1;
                        s_we     = 1'b1;
                        s_wdata  = id_reg + 1'b1;
                        top_next = '{node: cnt_reg[CELL_W-1:0], dir: 3'd0, via: '0};
                        sp_next  = SP_W'(1);
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            S_STEP:
            begin
                if (sp_reg == '0)
                    cnt_next = cnt_reg + 1'b1;
                else if (top_reg.dir[2])
                    sp_next = sp_reg - 1'b1;
                else
                begin
                    top_next.dir = top_reg.dir + 1'b1;
                    v_next       = nbr;
                end
            end
            S_POP:
                top_next = k_rdata;
            S_NREAD:
                w_next = p_rdata.node;
            S_WREAD:
            begin
                if ((s_rdata != id_reg) && (sp_reg < SP_W'(CELLS)))
                begin
                    s_we     = 1'b1;
                    s_waddr  = w_reg;
                    s_wdata  = id_reg;
                    k_we     = 1'b1;
                    top_next = '{node: w_reg, dir: 3'd0, via: v_reg};
                    sp_next  = sp_reg + 1'b1;
                end
            end
            S_BT_A:
            begin
                p_we    = 1'b1;
                p_waddr = top_reg.node;
                p_wdata = '{valid: 1'b1, node: v_reg};
            end
            S_BT_B:
            begin
                p_we    = 1'b1;
                p_waddr = v_reg;
                p_wdata = '{valid: 1'b1, node: top_reg.node};
                v_next  = top_reg.via;
                if (sp_reg == SP_W'(1))
                begin
                    pairs_next = pairs_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    sp_next    = '0;
                end
                else
                    sp_next = sp_reg - 1'b1;
            end
            S_BT_LD:
                top_next = k_rdata;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        free_reg  <= free_next;
        pairs_reg <= pairs_next;
        id_reg    <= id_next;
        sp_reg    <= sp_next;
        top_reg   <= top_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
    end

    always_ff @(posedge clk)
    begin
        if (p_we) partner_mem[p_waddr] <= p_wdata;
        p_rdata <= partner_mem[p_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we) stamp_mem[s_waddr] <= s_wdata;
        s_rdata <= stamp_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (k_we) stack_mem[k_waddr] <= k_wdata;
        k_rdata <= stack_mem[k_raddr];
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.tileable      = !free_reg[0] && ({pairs_reg, 1'b0} == {1'b0, free_reg});
    assign res.matched_pairs = 10'(pairs_reg);
    assign res.free_cells    = 11'(free_reg);

endmodule

>>> sv/grid_domino_tiling_check_top.sv
// Top level of the domino tiling check: size registers, channels, output register.
// Depends on gdt_pkg, gdt_map and gdt_search.
//
//  port group | dir | transfer when           | carries
//  -----------+-----+-------------------------+------------------------------
//  in_*       | in  | in_valid & !in_stall    | func, hole_row, hole_col
//  out_*      | out | out_valid & !out_stall  | tileable, matched_pairs, free_cells
//  cfg_*      | in  | cfg_we                  | grid_rows (0), grid_cols (1)
//
// A hole mark is written into the map on its transfer; marks can arrive back to back while in_stall is low.
// A check first sweeps all cells (clears partner/stamp memories and counts free
// cells), then scans each cell and runs a DFS from each free cell of even parity:
// an outside or blocked neighbor is skipped, a free unmatched one ends the search,
// a matched one pushes its partner if not yet visited, an exhausted frame pops, and
// each augmenting-path link is rewritten back to the root; the result then waits in the done state.
// in_stall is high after the check transfer until its result enters the output register.
// The result waits in the output register under out_stall; a new item is taken meanwhile.
// Reset clears the map and the control state; no clearing pass is needed after reset.
module grid_domino_tiling_check_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  gdt_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output gdt_pkg::out_t                   out_data,
    input  logic                            cfg_we,
    input  logic [gdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gdt_pkg::CFG_W-1:0]       cfg_data
);
    import gdt_pkg::*;

    logic [CFG_W-1:0] rows_reg, cols_reg;
    logic             out_valid_reg;
    out_t             out_data_reg;
    size_t            size;
    mark_t            mark;
    query_t           query;
    logic             blocked, idle, res_valid, take, in_xfer;
    out_t             res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_W'(8);
            cols_reg <= CFG_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data;
                CFG_COLS: cols_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sizes above the map saturate
    assign size.rows = (SZ_W'(rows_reg) > SZ_W'(MAX_ROWS)) ? SZ_W'(MAX_ROWS) : SZ_W'(rows_reg);
    assign size.cols = (SZ_W'(cols_reg) > SZ_W'(MAX_COLS)) ? SZ_W'(MAX_COLS) : SZ_W'(cols_reg);

    assign in_stall = !idle;
    assign in_xfer  = in_valid && !in_stall;

    // holes beyond the stored map are dropped
    assign mark.we  = in_xfer && !in_data.func
                      && (32'(in_data.hole_row) < MAX_ROWS)
                      && (32'(in_data.hole_col) < MAX_COLS);
    assign mark.row = ROW_W'(in_data.hole_row);
    assign mark.col = COL_W'(in_data.hole_col);

    gdt_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .mark    (mark),
        .query   (query),
        .blocked (blocked)
    );

    gdt_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_xfer && in_data.func),
        .size      (size),
        .blocked   (blocked),
        .take      (take),
        .query     (query),
        .idle      (idle),
        .res_valid (res_valid),
        .res       (res)
    );

    assign take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take) out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
